/* rtl/dact_pkg.sv */
// dact_pkg: shared types, codes and constants of the daily alarm and countdown timer
// no dependencies; used by the channel interfaces, dact_step and the top level

package dact_pkg;

    localparam int CFG_DATA_W = 6;
    localparam int CFG_IDX_W  = 2;

    localparam logic [11:0] MAX_DURATION = 12'(59 * 60 + 59);
    localparam logic [10:0] MIN_PER_HOUR = 11'd60;

    // event codes
    localparam logic [2:0] FUNC_TICK   = 3'd0;
    localparam logic [2:0] FUNC_GAP    = 3'd1;
    localparam logic [2:0] FUNC_START  = 3'd2;
    localparam logic [2:0] FUNC_CANCEL = 3'd3;
    localparam logic [2:0] FUNC_DISMISS = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_HOUR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_MINUTE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RING_REPEATS = 2'd3;

    // configuration reset values
    localparam logic [4:0] RST_ALARM_HOUR   = 5'd7;
    localparam logic [5:0] RST_ALARM_MINUTE = 6'd30;
    localparam logic [3:0] RST_RING_REPEATS = 4'd5;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_ALARM = 2'd1,
        KIND_TIMER = 2'd2
    } kind_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [4:0]  clock_hour;
        logic [5:0]  clock_minute;
        logic [5:0]  clock_second;
        logic        time_synced;
        logic [11:0] duration_s;
    } item_t;

    typedef struct packed {
        logic        status;
        logic [1:0]  beeps;
        logic        arm_gap_timer;
        logic        ring_started;
        logic        popup_hide;
        logic        dismissed;
        logic        ring_active;
        logic [1:0]  ring_source;
        logic        count_running;
        logic [11:0] count_left;
        logic        alarm_fired;
        logic        timer_fired;
    } result_t;

    typedef struct packed {
        logic       alarm_enable;
        logic [4:0] wake_hour;
        logic [5:0] alarm_minute;
        logic [3:0] ring_repeats;
    } cfg_t;

    typedef struct packed {
        logic        marker_valid;
        logic [10:0] marker_minute;
        logic        count_on;
        logic [11:0] count_value;
        logic        ring_flag;
        kind_t       ring_src;
        logic [3:0]  ring_left;
    } state_t;

endpackage

/* rtl/dact_in_if.sv */
// dact_in_if: valid/ready channel carrying one event item
// depends on dact_pkg

interface dact_in_if;
    logic            valid;
    logic            ready;
    dact_pkg::item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/dact_out_if.sv */
// dact_out_if: valid/ready channel carrying one result item
// depends on dact_pkg

interface dact_out_if;
    logic              valid;
    logic              ready;
    dact_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/daily_alarm_and_countdown_timer.sv */
// daily_alarm_and_countdown_timer: top level with channels, config registers and state
// depends on dact_pkg, dact_in_if, dact_out_if and dact_step
//
// Takes one event per clock cycle while the result side does not stall, a rate set by the
// combinational update of the alarm, countdown and ring state in dact_step, and returns
// exactly one result per event through the input register and then the result register.
// The result register parts the two channels: an empty input register takes a new event
// while a finished result waits, and a stall on the result side holds the pipeline without
// losing anything. Configuration writes are registered, clear the fired-minute marker, and
// are meant to be made while no event is in flight. No clearing pass is needed after reset.

module daily_alarm_and_countdown_timer (
    input  logic                                  clk,
    input  logic                                  rst_n,
    dact_in_if.sink                               in_ch,
    dact_out_if.source                            out_ch,
    input  logic                                  cfg_we,
    input  logic [dact_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [dact_pkg::CFG_DATA_W-1:0]       cfg_data
);

    logic              s1_valid_reg;
    dact_pkg::item_t   s1_item_reg;
    logic              out_valid_reg;
    dact_pkg::result_t out_data_reg;
    dact_pkg::state_t  state_reg;
    dact_pkg::state_t  state_next;
    dact_pkg::cfg_t    cfg_reg;
    dact_pkg::result_t step_result;
    logic              s1_advance;
    logic              step_fire;

    assign s1_advance  = !out_valid_reg || out_ch.ready;
    assign step_fire   = s1_valid_reg && s1_advance;
    assign in_ch.ready = !s1_valid_reg || s1_advance;

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

    dact_step u_step (
        .item       (s1_item_reg),
        .state      (state_reg),
        .cfg        (cfg_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
                s1_valid_reg <= in_ch.valid;
            if (s1_advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
            s1_item_reg <= in_ch.data;
        if (step_fire)
            out_data_reg <= step_result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= '0;
            cfg_reg.alarm_enable <= 1'b0;
            cfg_reg.wake_hour    <= dact_pkg::RST_ALARM_HOUR;
            cfg_reg.alarm_minute <= dact_pkg::RST_ALARM_MINUTE;
            cfg_reg.ring_repeats <= dact_pkg::RST_RING_REPEATS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dact_pkg::REG_ALARM_ENABLE: cfg_reg.alarm_enable <= cfg_data[0];
                dact_pkg::REG_ALARM_HOUR:   cfg_reg.wake_hour    <= cfg_data[4:0];
                dact_pkg::REG_ALARM_MINUTE: cfg_reg.alarm_minute <= cfg_data;
                dact_pkg::REG_RING_REPEATS: cfg_reg.ring_repeats <= cfg_data[3:0];
                default:                    cfg_reg.alarm_enable <= cfg_reg.alarm_enable;
            endcase
            // any config write forgets the fired minute
            state_reg.marker_valid  <= 1'b0;
            state_reg.marker_minute <= '0;
        end
        else if (step_fire)
        begin
            state_reg <= state_next;
        end
    end

    a_kind_matches_flag: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.ring_flag == (state_reg.ring_src != dact_pkg::KIND_NONE))
        else $error("ring kind and ring flag disagree");

    a_countdown_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.count_on |-> (state_reg.count_value != '0 &&
                                state_reg.count_value <= dact_pkg::MAX_DURATION))
        else $error("running countdown out of range");

    a_marker_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.marker_valid |-> state_reg.marker_minute == '0)
        else $error("stale fired-minute marker");

    a_double_beep: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.beeps == 2'd2) |->
            (out_data_reg.alarm_fired && out_data_reg.timer_fired &&
             out_data_reg.ring_source == dact_pkg::KIND_ALARM))
        else $error("double beep without both firing");

endmodule

/* rtl/dact_step.sv */
// dact_step: next-state and result logic for one event
// depends on dact_pkg

module dact_step (
    input  dact_pkg::item_t   item,
    input  dact_pkg::state_t  state,
    input  dact_pkg::cfg_t    cfg,
    output dact_pkg::state_t  state_next,
    output dact_pkg::result_t result
);

    logic [10:0] day_minute;
    logic        tfired;
    logic        afired;
    logic        marker_hit;

    assign day_minute = 11'(11'(item.clock_hour) * dact_pkg::MIN_PER_HOUR
                            + 11'(item.clock_minute));
    assign marker_hit = state.marker_valid && (state.marker_minute == day_minute);

    always_comb
    begin
        dact_pkg::state_t st;
        dact_pkg::result_t res;
        st     = state;
        res    = '0;
        tfired = 1'b0;
        afired = 1'b0;
        unique case (item.func)
            dact_pkg::FUNC_TICK:
            begin
                if (item.time_synced)
                begin
                    if (st.count_on)
                    begin
                        if (st.count_value != '0)
                            st.count_value = st.count_value - 12'd1;
                        if (st.count_value == '0)
                        begin
                            st.count_on = 1'b0;
                            tfired      = 1'b1;
                        end
                    end
                    // uses the ring flag from before this tick
                    if (cfg.alarm_enable && !state.ring_flag && item.clock_second == '0 &&
                        item.clock_hour == cfg.wake_hour &&
                        item.clock_minute == cfg.alarm_minute && !marker_hit)
                    begin
                        st.marker_valid  = 1'b1;
                        st.marker_minute = day_minute;
                        afired           = 1'b1;
                    end
                    if (st.marker_valid && st.marker_minute != day_minute)
                    begin
                        st.marker_valid  = 1'b0;
                        st.marker_minute = '0;
                    end
                    // timer ring first, alarm ring restarts it
                    if (tfired || afired)
                    begin
                        st.ring_flag = 1'b1;
                        st.ring_src  = afired ? dact_pkg::KIND_ALARM : dact_pkg::KIND_TIMER;
                        st.ring_left = cfg.ring_repeats;
                        res.ring_started  = 1'b1;
                        res.arm_gap_timer = 1'b1;
                    end
                    res.beeps = 2'(tfired) + 2'(afired);
                end
            end
            dact_pkg::FUNC_GAP:
            begin
                if (!st.ring_flag || st.ring_left == '0)
                begin
                    st.ring_flag   = 1'b0;
                    st.ring_src    = dact_pkg::KIND_NONE;
                    st.ring_left   = '0;
                    res.popup_hide = 1'b1;
                end
                else
                begin
                    st.ring_left      = st.ring_left - 4'd1;
                    res.beeps         = 2'd1;
                    res.arm_gap_timer = (st.ring_left != '0);
                end
            end
            dact_pkg::FUNC_START:
            begin
                if (item.duration_s == '0 || item.duration_s > dact_pkg::MAX_DURATION)
                    res.status = 1'b1;
                else
                begin
                    st.count_on    = 1'b1;
                    st.count_value = item.duration_s;
                end
            end
            dact_pkg::FUNC_CANCEL:
            begin
                st.count_on    = 1'b0;
                st.count_value = '0;
            end
            dact_pkg::FUNC_DISMISS:
            begin
                if (st.ring_flag)
                begin
                    st.ring_flag   = 1'b0;
                    st.ring_src    = dact_pkg::KIND_NONE;
                    st.ring_left   = '0;
                    res.popup_hide = 1'b1;
                    res.dismissed  = 1'b1;
                end
            end
            default:
            begin
                st = state;
            end
        endcase
        res.alarm_fired   = afired;
        res.timer_fired   = tfired;
        res.ring_active   = st.ring_flag;
        res.ring_source   = st.ring_src;
        res.count_running = st.count_on;
        res.count_left    = st.count_value;
        state_next = st;
        result     = res;
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// testbench: self-checking bench for daily_alarm_and_countdown_timer, with its own event predictor
// depends on dact_pkg, dact_in_if, dact_out_if and the rtl top level

module testbench;

    typedef logic [dact_pkg::CFG_DATA_W-1:0] cfg_word_t;
    typedef logic [dact_pkg::CFG_IDX_W-1:0]  cfg_idx_t;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    cfg_idx_t  cfg_index;
    cfg_word_t cfg_data;

    dact_in_if  in_ch ();
    dact_out_if out_ch ();

    daily_alarm_and_countdown_timer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor copy of configuration and state
    dact_pkg::cfg_t  alarm_cfg;
    logic            mark_valid;
    logic [10:0]     mark_minute;
    logic            count_on;
    logic [11:0]     count_value;
    logic            ring_on;
    dact_pkg::kind_t ring_src;
    logic [3:0]      beeps_left;

    dact_pkg::result_t expected_results[$];
    int                mismatch_count;
    bit                no_gaps;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic void start_ring(input dact_pkg::kind_t kind);
        ring_on    = 1'b1;
        ring_src   = kind;
        beeps_left = alarm_cfg.ring_repeats;
    endfunction

    function automatic void stop_ring();
        ring_on    = 1'b0;
        ring_src   = dact_pkg::KIND_NONE;
        beeps_left = 4'd0;
    endfunction

    function automatic void reset_predictor();
        alarm_cfg.alarm_enable = 1'b0;
        alarm_cfg.wake_hour    = dact_pkg::RST_ALARM_HOUR;
        alarm_cfg.alarm_minute = dact_pkg::RST_ALARM_MINUTE;
        alarm_cfg.ring_repeats = dact_pkg::RST_RING_REPEATS;
        mark_valid  = 1'b0;
        mark_minute = '0;
        count_on    = 1'b0;
        count_value = '0;
        stop_ring();
    endfunction

    function automatic dact_pkg::result_t predict_event(input dact_pkg::item_t it);
        dact_pkg::result_t r;
        logic [10:0]       day_minute;
        logic              tfire;
        logic              afire;
        r = '0;
        tfire = 1'b0;
        afire = 1'b0;
        day_minute = 11'(it.clock_hour) * dact_pkg::MIN_PER_HOUR + 11'(it.clock_minute);
        case (it.func)
            dact_pkg::FUNC_TICK:
            begin
                if (it.time_synced)
                begin
                    if (count_on)
                    begin
                        if (count_value != 12'd0)
                            count_value = count_value - 12'd1;
                        if (count_value == 12'd0)
                        begin
                            count_on = 1'b0;
                            tfire = 1'b1;
                        end
                    end
                    if (alarm_cfg.alarm_enable && !ring_on && it.clock_second == 6'd0 &&
                        it.clock_hour == alarm_cfg.wake_hour &&
                        it.clock_minute == alarm_cfg.alarm_minute &&
                        !(mark_valid && mark_minute == day_minute))
                    begin
                        mark_valid  = 1'b1;
                        mark_minute = day_minute;
                        afire = 1'b1;
                    end
                    if (mark_valid && mark_minute != day_minute)
                    begin
                        mark_valid  = 1'b0;
                        mark_minute = '0;
                    end
                    // timer ring first, alarm ring restarts it
                    if (tfire)
                    begin
                        start_ring(dact_pkg::KIND_TIMER);
                        r.beeps = r.beeps + 2'd1;
                    end
                    if (afire)
                    begin
                        start_ring(dact_pkg::KIND_ALARM);
                        r.beeps = r.beeps + 2'd1;
                    end
                    if (tfire || afire)
                    begin
                        r.ring_started  = 1'b1;
                        r.arm_gap_timer = 1'b1;
                    end
                end
            end
            dact_pkg::FUNC_GAP:
            begin
                if (!ring_on || beeps_left == 4'd0)
                begin
                    stop_ring();
                    r.popup_hide = 1'b1;
                end
                else
                begin
                    beeps_left = beeps_left - 4'd1;
                    r.beeps = 2'd1;
                    r.arm_gap_timer = (beeps_left != 4'd0);
                end
            end
            dact_pkg::FUNC_START:
            begin
                if (it.duration_s < 12'd1 || it.duration_s > dact_pkg::MAX_DURATION)
                    r.status = 1'b1;
                else
                begin
                    count_on    = 1'b1;
                    count_value = it.duration_s;
                end
            end
            dact_pkg::FUNC_CANCEL:
            begin
                count_on    = 1'b0;
                count_value = '0;
            end
            dact_pkg::FUNC_DISMISS:
            begin
                if (ring_on)
                begin
                    stop_ring();
                    r.popup_hide = 1'b1;
                    r.dismissed  = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.ring_active   = ring_on;
        r.ring_source   = ring_src;
        r.count_running = count_on;
        r.count_left    = count_value;
        r.alarm_fired   = afire;
        r.timer_fired   = tfire;
        return r;
    endfunction

    function automatic string diff_fields(input dact_pkg::result_t want,
                                          input dact_pkg::result_t got);
        string bad;
        bad = "";
        if (got.status !== want.status)               bad = {bad, " status"};
        if (got.beeps !== want.beeps)                 bad = {bad, " beeps"};
        if (got.arm_gap_timer !== want.arm_gap_timer) bad = {bad, " arm_gap_timer"};
        if (got.ring_started !== want.ring_started)   bad = {bad, " ring_started"};
        if (got.popup_hide !== want.popup_hide)       bad = {bad, " popup_hide"};
        if (got.dismissed !== want.dismissed)         bad = {bad, " dismissed"};
        if (got.ring_active !== want.ring_active)     bad = {bad, " ring_active"};
        if (got.ring_source !== want.ring_source)     bad = {bad, " ring_source"};
        if (got.count_running !== want.count_running) bad = {bad, " count_running"};
        if (got.count_left !== want.count_left)       bad = {bad, " count_left"};
        if (got.alarm_fired !== want.alarm_fired)     bad = {bad, " alarm_fired"};
        if (got.timer_fired !== want.timer_fired)     bad = {bad, " timer_fired"};
        return bad;
    endfunction

    always @(posedge clk)
    begin : result_check
        dact_pkg::result_t want;
        string             bad;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result %h with nothing pending", $realtime, out_ch.data);
            end
            else
            begin
                want = expected_results.pop_front();
                bad = diff_fields(want, out_ch.data);
                if (bad != "")
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: mismatch on%s: expected %h, got %h",
                                 $realtime, bad, want, out_ch.data);
                end
            end
        end
    end

    // result side: ready runs with random stalls, now and then a long run without any
    initial
    begin : result_sink
        int run;
        int stall;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
            stall = pick_gap();
            repeat (run)
            begin
                @(posedge clk);
                out_ch.ready <= 1'b1;
            end
            repeat (stall)
            begin
                @(posedge clk);
                out_ch.ready <= 1'b0;
            end
        end
    end

    task automatic send_event(input dact_pkg::item_t it);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        expected_results.push_back(predict_event(it));
    endtask

    // hold off the sender until every pending result has come back
    task automatic drain_results();
        int n;
        in_ch.valid <= 1'b0;
        for (n = 0; n < 20000 && expected_results.size() != 0; n++)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input cfg_word_t val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            dact_pkg::REG_ALARM_ENABLE: alarm_cfg.alarm_enable = val[0];
            dact_pkg::REG_ALARM_HOUR:   alarm_cfg.wake_hour    = val[4:0];
            dact_pkg::REG_ALARM_MINUTE: alarm_cfg.alarm_minute = val[5:0];
            dact_pkg::REG_RING_REPEATS: alarm_cfg.ring_repeats = val[3:0];
            default:                    ;
        endcase
        mark_valid  = 1'b0;
        mark_minute = '0;
    endtask

    task automatic set_config(input bit en, input int hour, input int minute, input int repeats);
        drain_results();
        write_reg(dact_pkg::REG_ALARM_ENABLE, cfg_word_t'(en));
        write_reg(dact_pkg::REG_ALARM_HOUR, cfg_word_t'(hour & 31));
        write_reg(dact_pkg::REG_ALARM_MINUTE, cfg_word_t'(minute & 63));
        write_reg(dact_pkg::REG_RING_REPEATS, cfg_word_t'(repeats & 15));
        cfg_we <= 1'b0;
    endtask

    function automatic dact_pkg::item_t mk_event(input logic [2:0] func, input int hour,
                                                 input int minute, input int second,
                                                 input bit synced, input int dur);
        dact_pkg::item_t it;
        it.func         = func;
        it.clock_hour   = 5'(hour);
        it.clock_minute = 6'(minute);
        it.clock_second = 6'(second);
        it.time_synced  = synced;
        it.duration_s   = 12'(dur);
        return it;
    endfunction

    // mostly ticks near the alarm minute and short countdowns, so rings happen often
    function automatic dact_pkg::item_t rand_event();
        dact_pkg::item_t it;
        int              sel;
        int              near;
        it.clock_hour   = 5'($urandom);
        it.clock_minute = 6'($urandom);
        it.clock_second = 6'($urandom);
        it.time_synced  = ($urandom_range(0, 9) != 0);
        it.duration_s   = 12'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 50)
        begin
            it.func = dact_pkg::FUNC_TICK;
            near = $urandom_range(0, 9);
            if (near < 6)
            begin
                it.clock_hour   = alarm_cfg.wake_hour;
                it.clock_minute = (near < 4) ? alarm_cfg.alarm_minute
                                             : alarm_cfg.alarm_minute + 6'd1;
            end
            if ($urandom_range(0, 1) == 0)
                it.clock_second = 6'd0;
        end
        else if (sel < 68)
            it.func = dact_pkg::FUNC_GAP;
        else if (sel < 76)
        begin
            it.func = dact_pkg::FUNC_START;
            near = $urandom_range(0, 19);
            if (near < 14)
                it.duration_s = 12'($urandom_range(1, 12));
            else if (near < 17)
                it.duration_s = 12'($urandom_range(1, 3599));
            else if (near < 18)
                it.duration_s = 12'd0;
            else
                it.duration_s = 12'($urandom_range(3600, 4095));
        end
        else if (sel < 80)
            it.func = dact_pkg::FUNC_CANCEL;
        else if (sel < 95)
            it.func = dact_pkg::FUNC_DISMISS;
        else
            it.func = 3'($urandom_range(5, 7));
        return it;
    endfunction

    task automatic test_event_basics();
        send_event(mk_event(dact_pkg::FUNC_TICK, 7, 30, 0, 1'b0, 0));
        send_event(mk_event(dact_pkg::FUNC_TICK, 23, 59, 60, 1'b1, 0));
        send_event(dact_pkg::item_t'('1));
        send_event(mk_event(3'd5, 0, 0, 0, 1'b0, 0));
        send_event(mk_event(dact_pkg::FUNC_START, 0, 0, 0, 1'b0, 0));
        send_event(mk_event(dact_pkg::FUNC_START, 0, 0, 0, 1'b0, 3600));
        send_event(mk_event(dact_pkg::FUNC_START, 31, 63, 63, 1'b1, 4095));
        send_event(mk_event(dact_pkg::FUNC_START, 0, 0, 0, 1'b0, 3599));
        // restart while counting
        send_event(mk_event(dact_pkg::FUNC_START, 0, 0, 0, 1'b0, 2));
        send_event(mk_event(dact_pkg::FUNC_TICK, 10, 0, 1, 1'b1, 0));
        send_event(mk_event(dact_pkg::FUNC_TICK, 10, 0, 2, 1'b1, 0));
        send_event(mk_event(dact_pkg::FUNC_GAP, 0, 0, 0, 1'b0, 0));
        send_event(mk_event(dact_pkg::FUNC_DISMISS, 0, 0, 0, 1'b0, 0));
        send_event(mk_event(dact_pkg::FUNC_DISMISS, 0, 0, 0, 1'b0, 0));
        send_event(mk_event(dact_pkg::FUNC_GAP, 0, 0, 0, 1'b0, 0));
        send_event(mk_event(dact_pkg::FUNC_START, 0, 0, 0, 1'b0, 5));
        send_event(mk_event(dact_pkg::FUNC_CANCEL, 0, 0, 0, 1'b0, 0));
    endtask

    task automatic test_alarm_marker();
        set_config(1'b1, 7, 30, 1);
        // timer and alarm fire on the same tick
        send_event(mk_event(dact_pkg::FUNC_START, 0, 0, 0, 1'b0, 1));
        send_event(mk_event(dact_pkg::FUNC_TICK, 7, 30, 0, 1'b1, 0));
        send_event(mk_event(dact_pkg::FUNC_GAP, 0, 0, 0, 1'b0, 0));
        send_event(mk_event(dact_pkg::FUNC_GAP, 0, 0, 0, 1'b0, 0));
        // same minute again is blocked, another minute clears the marker
        send_event(mk_event(dact_pkg::FUNC_TICK, 7, 30, 0, 1'b1, 0));
        send_event(mk_event(dact_pkg::FUNC_TICK, 7, 31, 5, 1'b1, 0));
        send_event(mk_event(dact_pkg::FUNC_TICK, 7, 30, 0, 1'b1, 0));
        send_event(mk_event(dact_pkg::FUNC_DISMISS, 0, 0, 0, 1'b0, 0));
        // config write clears the marker; zero repeats ends on the first gap
        set_config(1'b1, 7, 30, 0);
        send_event(mk_event(dact_pkg::FUNC_TICK, 7, 30, 0, 1'b1, 0));
        send_event(mk_event(dact_pkg::FUNC_GAP, 0, 0, 0, 1'b0, 0));
    endtask

    task automatic test_alarm_out_of_range();
        set_config(1'b1, 31, 63, 15);
        send_event(mk_event(dact_pkg::FUNC_TICK, 31, 63, 0, 1'b1, 0));
        send_event(mk_event(dact_pkg::FUNC_TICK, 31, 63, 0, 1'b1, 0));
        send_event(mk_event(dact_pkg::FUNC_DISMISS, 0, 0, 0, 1'b0, 0));
    endtask

    task automatic test_random_phases();
        int p;
        int i;
        for (p = 0; p < 8; p++)
        begin
            case (p)
                0: set_config(1'b1, 7, 30, 5);
                1: set_config(1'b1, 0, 0, 1);
                2: set_config(1'b1, 23, 59, 15);
                3: set_config(1'b1, 12, 15, 0);
                4: set_config(1'b0, $urandom_range(0, 23), $urandom_range(0, 59),
                              $urandom_range(1, 15));
                5: set_config(1'b1, $urandom_range(0, 31), $urandom_range(0, 63),
                              $urandom_range(0, 15));
                default: set_config(1'b1, $urandom_range(0, 23), $urandom_range(0, 59),
                                    $urandom_range(1, 15));
            endcase
            no_gaps = (p == 2 || p == 5);
            for (i = 0; i < 160; i++)
            begin
                if (i == 80)
                    drain_results();
                send_event(rand_event());
            end
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        mismatch_count = 0;
        no_gaps = 1'b0;
        reset_predictor();
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_event_basics();
        test_alarm_marker();
        test_alarm_out_of_range();
        test_random_phases();

        drain_results();
        repeat (8) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            mismatch_count++;
            $display("%0d results never arrived", expected_results.size());
        end
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* sim.f */
rtl/dact_pkg.sv
rtl/dact_in_if.sv
rtl/dact_out_if.sv
rtl/dact_step.sv
rtl/daily_alarm_and_countdown_timer.sv
dv/testbench.sv
